// File: sv/acsh_pkg.sv
// Package for the ADC channel scan history core.
// Holds field widths, register indexes, reference codes, the sequencer
// info struct and the multiplexer byte function. No dependencies.
package acsh_pkg;

    localparam int SAMPLE_W = 10;
    localparam int CHAN_W   = 3;
    localparam int SLOT_W   = 5;
    localparam int MUX_W    = 8;
    localparam int SUM_W    = 15;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;
    localparam int VREF_W     = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_READ   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VREF_SOURCE = 1'd1;

    // reference source codes
    localparam logic [VREF_W-1:0] VREF_INT_1V1  = 2'd0;
    localparam logic [VREF_W-1:0] VREF_INT_2V56 = 2'd1;
    localparam logic [VREF_W-1:0] VREF_EXT      = 2'd2;

    localparam logic [MUX_W-1:0] REFS_INT_1V1  = 8'h80;
    localparam logic [MUX_W-1:0] REFS_INT_2V56 = 8'hC0;
    localparam logic [MUX_W-1:0] REFS_EXT      = 8'h00;
    localparam logic [MUX_W-1:0] REF_KEEP_MASK = 8'hE0;

    // where the request being taken lands, and what follows it
    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic [SLOT_W-1:0] slot;
        logic              cycle_done;
        logic [CHAN_W-1:0] next_channel;
    } seq_info_t;

    function automatic logic [2:0] pin_code(input logic [CHAN_W-1:0] ch);
        logic [2:0] code;
        begin
            case (ch)
                3'd0:    code = 3'h0;
                3'd1:    code = 3'h2;
                3'd2:    code = 3'h3;
                3'd3:    code = 3'h4;
                3'd4:    code = 3'h5;
                3'd5:    code = 3'h6;
                default: code = 3'h0;
            endcase
            return code;
        end
    endfunction

    function automatic logic [MUX_W-1:0] mux_byte(
        input logic              diff,
        input logic [VREF_W-1:0] vref,
        input logic [CHAN_W-1:0] ch
    );
        logic [MUX_W-1:0] refs;
        begin
            case (vref)
                VREF_INT_2V56: refs = REFS_INT_2V56;
                VREF_EXT:      refs = REFS_EXT;
                default:       refs = REFS_INT_1V1;
            endcase
            return (refs & REF_KEEP_MASK) | {3'b000, diff, 1'b0, pin_code(ch)};
        end
    endfunction

endpackage

// File: sv/acsh_ram.sv
// Generic single write port, single read port RAM with registered read.
// Read returns the old contents on a same-address write. No dependencies.
module acsh_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/acsh_seq.sv
// Scan sequencer: pending channel, next channel and history slot counters.
// Produces the write address of the request taken now and the look-ahead
// read address of the one after it. Depends on acsh_pkg.
module acsh_seq #(
    parameter int HISTORY_DEPTH = 8,
    parameter int NUM_CHANNELS  = 6
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    output acsh_pkg::seq_info_t       info,
    output logic [$clog2(HISTORY_DEPTH*NUM_CHANNELS)-1:0] wr_addr,
    output logic [$clog2(HISTORY_DEPTH*NUM_CHANNELS)-1:0] rd_addr
);
    import acsh_pkg::*;

    localparam int CIW   = $clog2(NUM_CHANNELS);
    localparam int SW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int DEPTH = HISTORY_DEPTH * NUM_CHANNELS;
    localparam int AW    = $clog2(DEPTH);

    logic [CIW-1:0] pending_reg, pending_next;
    logic [CIW-1:0] next_reg,    next_next;
    logic [SW-1:0]  slot_reg,    slot_next;
    logic [SW-1:0]  slot_inc;
    logic [CIW-1:0] next_inc;
    logic           wrap;

    function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] s, input logic [CIW-1:0] c);
        begin
            return AW'(int'(s) * NUM_CHANNELS + int'(c));
        end
    endfunction

    always_comb
    begin
        wrap     = (next_reg == '0);
        slot_inc = (slot_reg == SW'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
        next_inc = (next_reg == CIW'(NUM_CHANNELS - 1)) ? '0 : next_reg + 1'b1;

        pending_next = pending_reg;
        next_next    = next_reg;
        slot_next    = slot_reg;
        if (advance)
        begin
            pending_next = next_reg;
            next_next    = next_inc;
            slot_next    = wrap ? slot_inc : slot_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            next_reg    <= '0;
            slot_reg    <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            next_reg    <= next_next;
            slot_reg    <= slot_next;
        end
    end

    always_comb
    begin
        info.channel      = CHAN_W'(pending_reg);
        info.slot         = SLOT_W'(slot_reg);
        info.cycle_done   = wrap;
        info.next_channel = CHAN_W'(next_inc);
        wr_addr           = addr_of(slot_reg, pending_reg);
        rd_addr           = addr_of(slot_next, pending_next);
    end

endmodule

// File: sv/adc_channel_scan_history_core.sv
// Top level of the ADC channel scan history core.
// Instantiates acsh_seq and acsh_ram; depends on acsh_pkg.
//
// One request carries one finished 10-bit conversion. The sample is stored in
// the history ring at the current slot for the pending channel; the pending
// and next channel counters then advance over NUM_CHANNELS channels, and the
// slot steps whenever the pending channel wraps to zero. Each request yields
// exactly one result in the cycle after it is taken: the channel and slot
// written, a cycle-complete flag, the multiplexer byte for the next channel
// (reference bits 7:6, differential bit 4, pin code 2:0) and the running
// history sum of the stored channel. A new request is taken every cycle; the
// only thing that holds the input back is a full result register under
// stall. The history ring lives in a RAM read one request ahead: the address
// of the following request is known from the counters, so its old entry is
// already registered when that request arrives, and a bypass covers the case
// where it was written by the request just before. Every ring entry has a
// valid bit cleared by reset, so no clearing pass is needed and the block
// accepts requests straight out of reset. The user must write configuration
// registers through the plain write port while the block is idle (unenforced).
module adc_channel_scan_history_core #(
    parameter int HISTORY_DEPTH = 8,
    parameter int NUM_CHANNELS  = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [acsh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [acsh_pkg::CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [acsh_pkg::SAMPLE_W-1:0]   sample,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [acsh_pkg::CHAN_W-1:0]     stored_channel,
    output logic [acsh_pkg::SLOT_W-1:0]     stored_slot,
    output logic                            cycle_done,
    output logic [acsh_pkg::MUX_W-1:0]      mux_select,
    output logic [acsh_pkg::SUM_W-1:0]      history_sum
);
    import acsh_pkg::*;

    localparam int DEPTH = HISTORY_DEPTH * NUM_CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CIW   = $clog2(NUM_CHANNELS);

    // configuration
    logic              diff_read_reg;
    logic [VREF_W-1:0] vref_source_reg;

    // handshake
    logic accept;
    logic out_valid_reg, out_valid_next;

    // sequencer
    seq_info_t      info;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  rd_addr;

    // history ring read path
    logic [SAMPLE_W-1:0] rd_data;
    logic [DEPTH-1:0]    valid_reg;
    logic                rd_valid_reg;
    logic                hit_reg;
    logic [SAMPLE_W-1:0] byp_data_reg;
    logic [SAMPLE_W-1:0] old_sample;

    // running sums
    logic [SUM_W-1:0] sums_reg [NUM_CHANNELS];
    logic [SUM_W-1:0] sum_next;
    logic [CIW-1:0]   ch_idx;

    // result register
    logic [CHAN_W-1:0] stored_channel_reg;
    logic [SLOT_W-1:0] stored_slot_reg;
    logic              cycle_done_reg;
    logic [MUX_W-1:0]  mux_select_reg;
    logic [SUM_W-1:0]  history_sum_reg;

    // ------------------------------------------------------------------
    // Configuration registers: out-of-range indexes fall through and drop.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_read_reg   <= 1'b0;
            vref_source_reg <= VREF_INT_1V1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DIFF_READ:   diff_read_reg   <= cfg_data[0];
                REG_VREF_SOURCE: vref_source_reg <= cfg_data[VREF_W-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: take a request whenever the result register is free or
    // is being emptied in the same cycle.
    // ------------------------------------------------------------------
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer counters
    // ------------------------------------------------------------------
    acsh_seq #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .NUM_CHANNELS  (NUM_CHANNELS)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .info    (info),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr)
    );

    // ------------------------------------------------------------------
    // History ring: write the new sample, pre-read the entry the next
    // request will displace.
    // ------------------------------------------------------------------
    acsh_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (accept),
        .waddr (wr_addr),
        .wdata (sample),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // valid bits stand in for clearing the ring after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
            hit_reg      <= accept && (wr_addr == rd_addr);
        end
    end

    // bypass data: the sample just written when read and write collide
    always_ff @(posedge clk)
    begin
        byp_data_reg <= sample;
    end

    always_comb
    begin
        if (hit_reg)
        begin
            old_sample = byp_data_reg;
        end
        else if (rd_valid_reg)
        begin
            old_sample = rd_data;
        end
        else
        begin
            old_sample = '0;
        end
    end

    // ------------------------------------------------------------------
    // Running sums: drop the displaced sample, add the new one. The true
    // sum never exceeds 8 * 1023 by default, so it fits the 15-bit field.
    // ------------------------------------------------------------------
    assign ch_idx   = info.channel[CIW-1:0];
    assign sum_next = sums_reg[ch_idx] - SUM_W'(old_sample) + SUM_W'(sample);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                sums_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            sums_reg[ch_idx] <= sum_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stored_channel_reg <= info.channel;
            stored_slot_reg    <= info.slot;
            cycle_done_reg     <= info.cycle_done;
            mux_select_reg     <= mux_byte(diff_read_reg, vref_source_reg, info.next_channel);
            history_sum_reg    <= sum_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign stored_channel = stored_channel_reg;
    assign stored_slot    = stored_slot_reg;
    assign cycle_done     = cycle_done_reg;
    assign mux_select     = mux_select_reg;
    assign history_sum    = history_sum_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a taken request shows its result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> out_valid)
        else $error("request taken but no result followed");

    // reported channel and slot stay inside their ranges
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (stored_channel < CHAN_W'(NUM_CHANNELS))
                   && (int'(stored_slot) < HISTORY_DEPTH))
        else $error("stored channel or slot out of range");

    // after a scan wrap the next channel is always channel one
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cycle_done) |-> (mux_select[2:0] == pin_code(3'd1)))
        else $error("mux pin code after wrap is not channel one");

endmodule
